FILE: hw/rtl/incoherent_dedisperser_unit_defines.svh
// ----------------------------------------------------------------------------
// Incoherent dedisperser assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef INCOHERENT_DEDISPERSER_UNIT_DEFINES_SVH
`define INCOHERENT_DEDISPERSER_UNIT_DEFINES_SVH

// property checked at every edge outside reset
`define IDU_ASSERT_AT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition in one cycle implies a condition in the next
`define IDU_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: hw/rtl/idd_pkg.sv
// ----------------------------------------------------------------------------
// Incoherent dedisperser package
// Sizes, codes, shared types and helper functions.
// ----------------------------------------------------------------------------
package idd_pkg;

    localparam int MAX_CHANNELS  = 1024;
    localparam int RING_DEPTH    = 1024;
    localparam int SAMPLE_BITS   = 16;

    localparam int CH_W          = $clog2(MAX_CHANNELS);
    localparam int NCH_W         = 11;
    localparam int DELAY_W       = 10;
    localparam int FILL_W        = 10;
    localparam int SLOT_W        = $clog2(RING_DEPTH);
    localparam int OFFSET_W      = 24;
    localparam int DATA_W        = 32;
    localparam int TIME_W        = 32;
    localparam int CFG_DATA_W    = 24;
    localparam int CFG_IDX_W     = 2;

    localparam int FILL_SAT      = 1023;
    localparam int MAX_EFF_DELAY = RING_DEPTH - 1;
    localparam int NCH_RESET     = 1024;

    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam int OQ_DEPTH      = 2;
    localparam int OQ_PTR_W      = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W      = $clog2(OQ_DEPTH + 1);

    localparam int CLR_CNT_W     = $clog2(RING_DEPTH + 1);

    typedef enum logic
    {
        REQ_LOAD   = 1'b0,
        REQ_SAMPLE = 1'b1
    } req_type_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_NUM_CHANNELS = 2'd0,
        CFG_MAX_DELAY    = 2'd1,
        CFG_MEAN_OFFSET  = 2'd2
    } cfg_idx_t;

    typedef struct packed
    {
        logic [NCH_W-1:0]           num_channels;
        logic [DELAY_W-1:0]         max_delay;
        logic signed [OFFSET_W-1:0] mean_offset;
    } cfg_t;

    // one queued word: an optional accumulate and an optional emit-and-clear
    typedef struct packed
    {
        logic                          add;
        logic                          emit;
        logic [SLOT_W-1:0]             add_slot;
        logic [SLOT_W-1:0]             emit_slot;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [TIME_W-1:0]             time_index;
    } op_t;

    typedef struct packed
    {
        logic clearing;
    } back_stat_t;

    function automatic logic [DELAY_W-1:0] eff_max_delay(input logic [DELAY_W-1:0] m);
        logic [DELAY_W-1:0] lim;
        lim = DELAY_W'(MAX_EFF_DELAY);
        return (m > lim) ? lim : m;
    endfunction

    function automatic logic [NCH_W-1:0] eff_channels(input logic [NCH_W-1:0] n);
        logic [NCH_W-1:0] lim;
        lim = NCH_W'(MAX_CHANNELS);
        if (n == '0)
        begin
            return NCH_W'(1);
        end
        return (n > lim) ? lim : n;
    endfunction

    function automatic logic [DATA_W-1:0] sext_sample(input logic [SAMPLE_BITS-1:0] s);
        return {{(DATA_W - SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s};
    endfunction

    function automatic logic [DATA_W-1:0] sext_offset(input logic [OFFSET_W-1:0] o);
        return {{(DATA_W - OFFSET_W){o[OFFSET_W-1]}}, o};
    endfunction

endpackage

FILE: hw/rtl/idd_front.sv
// ----------------------------------------------------------------------------
// Dedisperser front end
// Accepts words, keeps the delay table and the channel/spectrum counters,
// and turns each sample into a queued accumulate/emit word, unless it has neither.
// ----------------------------------------------------------------------------
module idd_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  idd_pkg::cfg_t                 cfg,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic                          req_type,
    input  logic [idd_pkg::CH_W-1:0]      table_channel,
    input  logic [idd_pkg::DELAY_W-1:0]   delay_bins,
    input  logic [idd_pkg::SAMPLE_BITS-1:0] sample,
    input  idd_pkg::back_stat_t           stat,
    input  logic                          q_full,
    output logic                          push,
    output idd_pkg::op_t                  push_op
);
    import idd_pkg::*;

    logic [DELAY_W-1:0]     delay_mem [MAX_CHANNELS];
    logic [DELAY_W-1:0]     dly_rd_reg;

    logic [CH_W-1:0]        chan_reg, chan_next;
    logic [TIME_W-1:0]      spec_reg, spec_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic                   f1_valid_reg, f1_valid_next;

    logic [SLOT_W-1:0]      f1_spec_reg;
    logic [DELAY_W-1:0]     f1_m_reg;
    logic [FILL_W-1:0]      f1_fill_reg;
    logic [SAMPLE_BITS-1:0] f1_sample_reg;
    logic                   f1_emit_reg;
    logic [TIME_W-1:0]      f1_t_reg;

    logic [DELAY_W-1:0]     m_eff;
    logic [NCH_W-1:0]       n_eff;
    logic                   acc_load;
    logic                   acc_smp;
    logic                   last_ch;
    logic                   emit_now;
    logic [DELAY_W-1:0]     d_clamp;
    logic                   add_ok;

    always_comb
    begin
        m_eff     = eff_max_delay(cfg.max_delay);
        n_eff     = eff_channels(cfg.num_channels);
        req_ready = !stat.clearing && (!f1_valid_reg || !q_full);
        acc_load  = req_valid && req_ready && (req_type == REQ_LOAD);
        acc_smp   = req_valid && req_ready && (req_type == REQ_SAMPLE);
        // a lowered channel count ends the spectrum at once
        last_ch   = (NCH_W'(chan_reg) + NCH_W'(1)) >= n_eff;
        emit_now  = last_ch && (FILL_W'(m_eff) <= fill_reg);
    end

    always_comb
    begin
        chan_next = chan_reg;
        spec_next = spec_reg;
        fill_next = fill_reg;
        if (acc_smp)
        begin
            if (last_ch)
            begin
                chan_next = '0;
                spec_next = spec_reg + TIME_W'(1);
                if (fill_reg < FILL_W'(FILL_SAT))
                begin
                    fill_next = fill_reg + FILL_W'(1);
                end
            end
            else
            begin
                chan_next = chan_reg + CH_W'(1);
            end
        end
    end

    always_comb
    begin
        f1_valid_next = f1_valid_reg;
        if (acc_smp)
        begin
            f1_valid_next = 1'b1;
        end
        else if (!q_full)
        begin
            f1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg     <= '0;
            spec_reg     <= '0;
            fill_reg     <= '0;
            f1_valid_reg <= 1'b0;
        end
        else
        begin
            chan_reg     <= chan_next;
            spec_reg     <= spec_next;
            fill_reg     <= fill_next;
            f1_valid_reg <= f1_valid_next;
        end
    end

    // delay table: written by load words, read for each accepted sample
    always_ff @(posedge clk)
    begin
        if (acc_load)
        begin
            delay_mem[table_channel] <= delay_bins;
        end
        if (acc_smp)
        begin
            dly_rd_reg <= delay_mem[chan_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_smp)
        begin
            f1_spec_reg   <= spec_reg[SLOT_W-1:0];
            f1_m_reg      <= m_eff;
            f1_fill_reg   <= fill_reg;
            f1_sample_reg <= sample;
            f1_emit_reg   <= emit_now;
            f1_t_reg      <= spec_reg - TIME_W'(m_eff);
        end
    end

    always_comb
    begin
        d_clamp = (dly_rd_reg > f1_m_reg) ? f1_m_reg : dly_rd_reg;
        // targets before time zero are dropped
        add_ok  = FILL_W'(d_clamp) <= f1_fill_reg;

        push_op.add        = add_ok;
        push_op.emit       = f1_emit_reg;
        push_op.add_slot   = f1_spec_reg - SLOT_W'(d_clamp);
        push_op.emit_slot  = f1_t_reg[SLOT_W-1:0];
        push_op.sample     = f1_sample_reg;
        push_op.time_index = f1_t_reg;

        push = f1_valid_reg && !q_full && (add_ok || f1_emit_reg);
    end

endmodule

FILE: hw/rtl/idd_queue.sv
// ----------------------------------------------------------------------------
// Dedisperser work queue
// Short FIFO of accumulate/emit words between front and back ends.
// ----------------------------------------------------------------------------
module idd_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  idd_pkg::op_t  push_op,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output idd_pkg::op_t  head_op
);
    import idd_pkg::*;

    op_t               ops [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        full        = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
        head_valid  = (cnt_reg != '0);
        head_op     = ops[rd_ptr_reg];
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ops[wr_ptr_reg] <= push_op;
        end
    end

endmodule

FILE: hw/rtl/idd_back.sv
// ----------------------------------------------------------------------------
// Dedisperser back end
// Accumulator ring, one read-modify-write per cycle when not stalled;
// emit-and-clear of done slots, start-up clearing, two-word result buffer.
// ----------------------------------------------------------------------------
module idd_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  idd_pkg::cfg_t               cfg,
    input  logic                        head_valid,
    input  idd_pkg::op_t                head_op,
    output logic                        pop,
    output idd_pkg::back_stat_t         stat,
    output logic                        res_valid,
    input  logic                        res_ready,
    output logic [idd_pkg::DATA_W-1:0]  dedispersed,
    output logic [idd_pkg::TIME_W-1:0]  time_index
);
    import idd_pkg::*;

    logic [DATA_W-1:0]      ring [RING_DEPTH];
    logic [DATA_W-1:0]      rd_data_reg;

    logic                   clr_active_reg, clr_active_next;
    logic [SLOT_W-1:0]      clr_addr_reg, clr_addr_next;

    logic                   phase_reg, phase_next;

    logic                   e_valid_reg;
    logic                   e_emit_reg;
    logic [SLOT_W-1:0]      e_slot_reg;
    logic [SAMPLE_BITS-1:0] e_sample_reg;
    logic [TIME_W-1:0]      e_time_reg;

    logic                   lw_valid_reg;
    logic [SLOT_W-1:0]      lw_slot_reg;
    logic [DATA_W-1:0]      lw_data_reg;

    logic [DATA_W-1:0]      oq_val  [OQ_DEPTH];
    logic [TIME_W-1:0]      oq_time [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]    oq_wr_reg, oq_rd_reg;
    logic [OQ_CNT_W-1:0]    oq_cnt_reg, oq_cnt_next;

    logic                   want_add, want_emit, emit_ok;
    logic                   issue_add, issue_emit, issue;
    logic [SLOT_W-1:0]      rd_slot;
    logic [DATA_W-1:0]      cur;
    logic [DATA_W-1:0]      e_new;
    logic                   oq_push, oq_pop;

    assign stat.clearing = clr_active_reg;

    // issue: an add-and-emit word runs as accumulate, then emit-and-clear
    always_comb
    begin
        want_add   = head_valid && head_op.add && !phase_reg;
        want_emit  = head_valid && head_op.emit && (phase_reg || !head_op.add);
        // room for this emit even if the one in flight also lands
        emit_ok    = (oq_cnt_reg + OQ_CNT_W'(e_valid_reg && e_emit_reg)) < OQ_CNT_W'(OQ_DEPTH);
        issue_add  = want_add && !clr_active_reg;
        issue_emit = want_emit && emit_ok && !clr_active_reg;
        issue      = issue_add || issue_emit;
        pop        = issue_emit || (issue_add && !head_op.emit);
        rd_slot    = issue_emit ? head_op.emit_slot : head_op.add_slot;

        phase_next = phase_reg;
        if (issue_emit)
        begin
            phase_next = 1'b0;
        end
        else if (issue_add && head_op.emit)
        begin
            phase_next = 1'b1;
        end
    end

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + SLOT_W'(1);
            if (clr_addr_reg == SLOT_W'(RING_DEPTH - 1))
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    // execute: forward last cycle's write, it is not yet in the read data
    always_comb
    begin
        cur   = (lw_valid_reg && (lw_slot_reg == e_slot_reg)) ? lw_data_reg : rd_data_reg;
        e_new = e_emit_reg ? '0 : cur + sext_sample(e_sample_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            phase_reg      <= 1'b0;
            e_valid_reg    <= 1'b0;
            e_emit_reg     <= 1'b0;
            lw_valid_reg   <= 1'b0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            phase_reg      <= phase_next;
            e_valid_reg    <= issue;
            e_emit_reg     <= issue_emit;
            lw_valid_reg   <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            e_slot_reg   <= rd_slot;
            e_sample_reg <= head_op.sample;
            e_time_reg   <= head_op.time_index;
        end
        if (e_valid_reg)
        begin
            lw_slot_reg <= e_slot_reg;
            lw_data_reg <= e_new;
        end
    end

    // accumulator ring: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= ring[rd_slot];
        if (clr_active_reg)
        begin
            ring[clr_addr_reg] <= '0;
        end
        else if (e_valid_reg)
        begin
            ring[e_slot_reg] <= e_new;
        end
    end

    // result buffer
    always_comb
    begin
        oq_push     = e_valid_reg && e_emit_reg;
        res_valid   = (oq_cnt_reg != '0);
        oq_pop      = res_valid && res_ready;
        dedispersed = oq_val[oq_rd_reg];
        time_index  = oq_time[oq_rd_reg];
        oq_cnt_next = oq_cnt_reg;
        if (oq_push && !oq_pop)
        begin
            oq_cnt_next = oq_cnt_reg + OQ_CNT_W'(1);
        end
        else if (oq_pop && !oq_push)
        begin
            oq_cnt_next = oq_cnt_reg - OQ_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            oq_cnt_reg <= oq_cnt_next;
            if (oq_push)
            begin
                oq_wr_reg <= oq_wr_reg + OQ_PTR_W'(1);
            end
            if (oq_pop)
            begin
                oq_rd_reg <= oq_rd_reg + OQ_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_val[oq_wr_reg]  <= cur - sext_offset(cfg.mean_offset);
            oq_time[oq_wr_reg] <= e_time_reg;
        end
    end

endmodule

FILE: hw/rtl/incoherent_dedisperser_unit.sv
// ----------------------------------------------------------------------------
// Incoherent dedisperser, top level
// Streaming shift-and-add over time-ordered spectra into a ring of
// accumulators; one dedispersed word per spectrum after the first max_delay.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------------
//   request  | req_valid / req_ready | req_type, table_channel, delay_bins, sample
//   result   | res_valid / res_ready | dedispersed, time_index
//   config   | cfg_write             | cfg_index, cfg_data
//
// One word per cycle is taken while the queue has room. The ring does one
// read-modify-write a cycle, and the last sample of a spectrum adds an
// emit-and-clear after its accumulate, or runs it alone if its own target is
// dropped; load words never reach the ring.
// A result passes the front register, queue, ring stages and result buffer.
// After reset every ring slot is swept to zero while req_ready is held low.
// A stalled result side fills a two-word buffer, then the queue, then
// holds req_ready low.
// ----------------------------------------------------------------------------
module incoherent_dedisperser_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [idd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [idd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  logic                             req_type,
    input  logic [idd_pkg::CH_W-1:0]         table_channel,
    input  logic [idd_pkg::DELAY_W-1:0]      delay_bins,
    input  logic [idd_pkg::SAMPLE_BITS-1:0]  sample,
    output logic                             res_valid,
    input  logic                             res_ready,
    output logic [idd_pkg::DATA_W-1:0]       dedispersed,
    output logic [idd_pkg::TIME_W-1:0]       time_index
);
    import idd_pkg::*;

    cfg_t       cfg_reg;
    back_stat_t stat;
    logic       q_full;
    logic       push;
    op_t        push_op;
    logic       pop;
    logic       head_valid;
    op_t        head_op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_channels <= NCH_W'(NCH_RESET);
            cfg_reg.max_delay    <= '0;
            cfg_reg.mean_offset  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_NUM_CHANNELS: cfg_reg.num_channels <= cfg_data[NCH_W-1:0];
                CFG_MAX_DELAY:    cfg_reg.max_delay    <= cfg_data[DELAY_W-1:0];
                CFG_MEAN_OFFSET:  cfg_reg.mean_offset  <= cfg_data[OFFSET_W-1:0];
                default:          ;
            endcase
        end
    end

    idd_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req_type      (req_type),
        .table_channel (table_channel),
        .delay_bins    (delay_bins),
        .sample        (sample),
        .stat          (stat),
        .q_full        (q_full),
        .push          (push),
        .push_op       (push_op)
    );

    idd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    idd_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head_valid  (head_valid),
        .head_op     (head_op),
        .pop         (pop),
        .stat        (stat),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .dedispersed (dedispersed),
        .time_index  (time_index)
    );

endmodule

FILE: hw/rtl/idd_checker.sv
// ----------------------------------------------------------------------------
// Dedisperser port checker
// Watches the top-level ports: start-up sweep, result ordering and holding.
// ----------------------------------------------------------------------------
`include "incoherent_dedisperser_unit_defines.svh"

module idd_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic                            req_valid,
    input  logic                            req_ready,
    input  logic                            req_type,
    input  logic                            res_valid,
    input  logic                            res_ready,
    input  logic [idd_pkg::DATA_W-1:0]      dedispersed,
    input  logic [idd_pkg::TIME_W-1:0]      time_index
);
    import idd_pkg::*;

    logic [CLR_CNT_W-1:0] boot_cnt_reg;
    logic                 seen_sample_reg;
    logic                 have_last_reg;
    logic                 cfg_dirty_reg;
    logic [TIME_W-1:0]    last_t_reg;
    logic                 res_acc;

    assign res_acc = res_valid && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boot_cnt_reg    <= '0;
            seen_sample_reg <= 1'b0;
            have_last_reg   <= 1'b0;
            cfg_dirty_reg   <= 1'b0;
            last_t_reg      <= '0;
        end
        else
        begin
            if (boot_cnt_reg < CLR_CNT_W'(RING_DEPTH))
            begin
                boot_cnt_reg <= boot_cnt_reg + CLR_CNT_W'(1);
            end
            if (req_valid && req_ready && (req_type == REQ_SAMPLE))
            begin
                seen_sample_reg <= 1'b1;
            end
            if (res_acc)
            begin
                have_last_reg <= 1'b1;
                last_t_reg    <= time_index;
            end
            if (cfg_write)
            begin
                cfg_dirty_reg <= 1'b1;
            end
            else if (res_acc)
            begin
                cfg_dirty_reg <= 1'b0;
            end
        end
    end

    `IDU_ASSERT_AT(a_sweep_blocks_input, clk, rst_n,
        (boot_cnt_reg < CLR_CNT_W'(RING_DEPTH)) |-> !req_ready,
        "input taken during start-up ring sweep")

    `IDU_ASSERT_AT(a_result_needs_sample, clk, rst_n,
        res_valid |-> seen_sample_reg,
        "result word before any sample word")

    `IDU_ASSERT_AT(a_time_in_sequence, clk, rst_n,
        (res_acc && have_last_reg && !cfg_dirty_reg && !cfg_write) |->
            (time_index == last_t_reg + TIME_W'(1)),
        "result time bins not consecutive")

    `IDU_ASSERT_NEXT(a_result_held, clk, rst_n,
        res_valid && !res_ready,
        res_valid && $stable(dedispersed) && $stable(time_index),
        "stalled result word changed")

endmodule

bind incoherent_dedisperser_unit idd_checker u_idd_checker (.*);
